[hdl/vrp_pkg.sv]
package vrp_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int TRIG_W     = 16;
  localparam int SCR_W      = 12;

  // Rotation datapath: inputs carry up to 20 significant bits, outputs 21
  localparam int ROT_W      = 20;
  localparam int ROT_OUT_W  = 21;
  localparam int FRAC_SHIFT = 14;

  // Projection and division
  localparam int PROJ_SCALE = 35;
  localparam int MAG_W      = 27;
  localparam int DIV_W      = 20;
  localparam int QUO_W      = 12;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_COS_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIN_X    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COS_Y    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIN_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COS_Z    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SIN_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CAM_DIST = 3'd6;

  localparam logic signed [TRIG_W-1:0]  TRIG_ONE      = 16'sd16384;
  localparam logic signed [TRIG_W-1:0]  TRIG_ZERO     = 16'sd0;
  localparam logic signed [COORD_W-1:0] CAM_DIST_RST  = 16'sd2560;

  localparam logic [SCR_W-1:0] SCR_MAX = 12'h7FF;
  localparam logic [SCR_W-1:0] SCR_MIN = 12'h800;

  // One divider lane: partial remainder, numerator bits still to shift in,
  // quotient bits gathered so far, sign of the result and overflow flag.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             sat;
  } div_lane_t;

  // Control that travels beside both divider lanes.
  typedef struct packed {
    logic             valid;
    logic             invalid;
    logic [DIV_W-1:0] divisor;
  } div_ctl_t;

endpackage

[hdl/vrp_rotate.sv]
module vrp_rotate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [vrp_pkg::ROT_W-1:0]      a_i,
  input  logic signed [vrp_pkg::ROT_W-1:0]      b_i,
  input  logic signed [vrp_pkg::ROT_W-1:0]      p_i,
  input  logic signed [vrp_pkg::TRIG_W-1:0]     cos_i,
  input  logic signed [vrp_pkg::TRIG_W-1:0]     sin_i,
  output logic                                  valid_o,
  output logic signed [vrp_pkg::ROT_OUT_W-1:0]  c_o,
  output logic signed [vrp_pkg::ROT_OUT_W-1:0]  s_o,
  output logic signed [vrp_pkg::ROT_W-1:0]      p_o
);
  import vrp_pkg::*;

  localparam int PROD_W = ROT_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] prod_ac, prod_bs, prod_as, prod_bc;
  logic signed [SUM_W-1:0]  sum_c, sum_s;
  logic                     valid_q;
  logic signed [ROT_OUT_W-1:0] c_q, s_q;
  logic signed [ROT_W-1:0]     p_q;

  // Four products, then the two plane sums in Q.22.
  assign prod_ac = a_i * cos_i;
  assign prod_bs = b_i * sin_i;
  assign prod_as = a_i * sin_i;
  assign prod_bc = b_i * cos_i;
  assign sum_c   = {prod_ac[PROD_W-1], prod_ac} - {prod_bs[PROD_W-1], prod_bs};
  assign sum_s   = {prod_as[PROD_W-1], prod_as} + {prod_bc[PROD_W-1], prod_bc};

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Dropping the low fraction bits of a two's complement sum rounds toward
  // minus infinity.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= sum_c[FRAC_SHIFT +: ROT_OUT_W];
      s_q <= sum_s[FRAC_SHIFT +: ROT_OUT_W];
      p_q <= p_i;
    end
  end

  assign valid_o = valid_q;
  assign c_o     = c_q;
  assign s_o     = s_q;
  assign p_o     = p_q;

endmodule

[hdl/vrp_prep.sv]
module vrp_prep (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [vrp_pkg::ROT_OUT_W-1:0]  x3_i,
  input  logic signed [vrp_pkg::ROT_OUT_W-1:0]  y3_i,
  input  logic signed [vrp_pkg::ROT_W-1:0]      z2_i,
  input  logic signed [vrp_pkg::COORD_W-1:0]    cam_dist_i,
  output vrp_pkg::div_ctl_t                     ctl_o,
  output vrp_pkg::div_lane_t                    lane_x_o,
  output vrp_pkg::div_lane_t                    lane_y_o
);
  import vrp_pkg::*;

  // Stage one: magnitudes, signs and the depth divisor.
  logic                        va_q, vb_q, vc_q;
  logic [ROT_OUT_W-1:0]        ax_d, ay_d, ax_q, ay_q;
  logic signed [ROT_OUT_W-1:0] depth_d;
  logic                        inv_d;
  logic                        nx_a_q, ny_a_q, inv_a_q;
  logic [DIV_W-1:0]            dv_a_q;
  // Stage two: scaled magnitudes.
  logic [MAG_W-1:0]            mx_d, my_d, mx_q, my_q;
  logic                        nx_b_q, ny_b_q, inv_b_q;
  logic [DIV_W-1:0]            dv_b_q;
  // Stage three: loaded divider lanes.
  div_lane_t                   lx_d, ly_d, lx_q, ly_q;
  logic                        inv_c_q;
  logic [DIV_W-1:0]            dv_c_q;

  assign ax_d    = x3_i[ROT_OUT_W-1] ? ROT_OUT_W'(-x3_i) : ROT_OUT_W'(x3_i);
  assign ay_d    = y3_i[ROT_OUT_W-1] ? ROT_OUT_W'(-y3_i) : ROT_OUT_W'(y3_i);
  assign depth_d = {z2_i[ROT_W-1], z2_i}
                 + {{(ROT_OUT_W-COORD_W){cam_dist_i[COORD_W-1]}}, cam_dist_i};
  assign inv_d   = depth_d[ROT_OUT_W-1] || (depth_d == '0);

  assign mx_d = MAG_W'(ax_q) * MAG_W'(PROJ_SCALE);
  assign my_d = MAG_W'(ay_q) * MAG_W'(PROJ_SCALE);

  // A quotient of 4096 or more saturates either way; otherwise the upper
  // numerator bits are already below the divisor and seed the remainder.
  always_comb begin
    lx_d.rem = DIV_W'(mx_q[MAG_W-1:QUO_W]);
    lx_d.num = mx_q[QUO_W-1:0];
    lx_d.quo = '0;
    lx_d.neg = nx_b_q;
    lx_d.sat = DIV_W'(mx_q[MAG_W-1:QUO_W]) >= dv_b_q;
    ly_d.rem = DIV_W'(my_q[MAG_W-1:QUO_W]);
    ly_d.num = my_q[QUO_W-1:0];
    ly_d.quo = '0;
    ly_d.neg = ny_b_q;
    ly_d.sat = DIV_W'(my_q[MAG_W-1:QUO_W]) >= dv_b_q;
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      nx_a_q  <= x3_i[ROT_OUT_W-1];
      ny_a_q  <= y3_i[ROT_OUT_W-1];
      inv_a_q <= inv_d;
      dv_a_q  <= depth_d[DIV_W-1:0];

      mx_q    <= mx_d;
      my_q    <= my_d;
      nx_b_q  <= nx_a_q;
      ny_b_q  <= ny_a_q;
      inv_b_q <= inv_a_q;
      dv_b_q  <= dv_a_q;

      lx_q    <= lx_d;
      ly_q    <= ly_d;
      inv_c_q <= inv_b_q;
      dv_c_q  <= dv_b_q;
    end
  end

  assign ctl_o.valid   = vc_q;
  assign ctl_o.invalid = inv_c_q;
  assign ctl_o.divisor = dv_c_q;
  assign lane_x_o      = lx_q;
  assign lane_y_o      = ly_q;

endmodule

[hdl/vrp_divstep.sv]
module vrp_divstep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  vrp_pkg::div_ctl_t  ctl_i,
  input  vrp_pkg::div_lane_t lane_x_i,
  input  vrp_pkg::div_lane_t lane_y_i,
  output vrp_pkg::div_ctl_t  ctl_o,
  output vrp_pkg::div_lane_t lane_x_o,
  output vrp_pkg::div_lane_t lane_y_o
);
  import vrp_pkg::*;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic div_lane_t div_step(div_lane_t l, logic [DIV_W-1:0] dv);
    logic [DIV_W:0] t;
    div_lane_t      r;
    r = l;
    t = {l.rem, l.num[QUO_W-1]};
    if (t >= {1'b0, dv}) begin
      r.rem = DIV_W'(t - {1'b0, dv});
      r.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = t[DIV_W-1:0];
      r.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    r.num = {l.num[QUO_W-2:0], 1'b0};
    return r;
  endfunction

  div_lane_t        lx_d, ly_d, lx_q, ly_q;
  logic             valid_q, invalid_q;
  logic [DIV_W-1:0] divisor_q;

  // Both lanes share the divisor.
  always_comb begin
    lx_d = lane_x_i;
    ly_d = lane_y_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      lx_d = div_step(lx_d, ctl_i.divisor);
      ly_d = div_step(ly_d, ctl_i.divisor);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx_q      <= lx_d;
      ly_q      <= ly_d;
      invalid_q <= ctl_i.invalid;
      divisor_q <= ctl_i.divisor;
    end
  end

  assign ctl_o.valid   = valid_q;
  assign ctl_o.invalid = invalid_q;
  assign ctl_o.divisor = divisor_q;
  assign lane_x_o      = lx_q;
  assign lane_y_o      = ly_q;

endmodule

[hdl/vertex_rotate_project.sv]
// Pipeline: 3 rotation, 3 scaling, 6 division and 1 output stage.
// Throughput: one vertex per clock unless a finished word waits on the output;
// the datapath is fully pipelined and every stage moves together on one enable
// that the output register sets.
// Reset: rst_ni clears all valid bits at once and returns the angle registers
// to an identity rotation and the camera distance to 10.0.
module vertex_rotate_project (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input vertex stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  logic [47:0]                      s_axis_tdata,
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: screen_x [11:0], screen_y [23:12]
  output logic [23:0]                      m_axis_tdata,
  // tuser: depth_invalid [0]
  output logic                             m_axis_tuser,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vrp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vrp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [vrp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import vrp_pkg::*;

  // Configuration registers
  logic signed [TRIG_W-1:0]  cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
  logic signed [COORD_W-1:0] cam_dist_q;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic                      cfg_wr;
  logic [TRIG_W-1:0]         rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_x_q    <= TRIG_ONE;
      sin_x_q    <= TRIG_ZERO;
      cos_y_q    <= TRIG_ONE;
      sin_y_q    <= TRIG_ZERO;
      cos_z_q    <= TRIG_ONE;
      sin_z_q    <= TRIG_ZERO;
      cam_dist_q <= CAM_DIST_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COS_X:    cos_x_q    <= pwdata[TRIG_W-1:0];
        REG_SIN_X:    sin_x_q    <= pwdata[TRIG_W-1:0];
        REG_COS_Y:    cos_y_q    <= pwdata[TRIG_W-1:0];
        REG_SIN_Y:    sin_y_q    <= pwdata[TRIG_W-1:0];
        REG_COS_Z:    cos_z_q    <= pwdata[TRIG_W-1:0];
        REG_SIN_Z:    sin_z_q    <= pwdata[TRIG_W-1:0];
        REG_CAM_DIST: cam_dist_q <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back, sign-extended to the bus.
  always_comb begin
    unique case (reg_idx)
      REG_COS_X:    rd_val = cos_x_q;
      REG_SIN_X:    rd_val = sin_x_q;
      REG_COS_Y:    rd_val = cos_y_q;
      REG_SIN_Y:    rd_val = sin_y_q;
      REG_COS_Z:    rd_val = cos_z_q;
      REG_SIN_Z:    rd_val = sin_z_q;
      REG_CAM_DIST: rd_val = cam_dist_q;
      default:      rd_val = '0;
    endcase
  end
  assign prdata = {{(APB_DATA_W-TRIG_W){rd_val[TRIG_W-1]}}, rd_val};

  // Whole pipeline advances unless a finished word waits on the output.
  logic out_valid_q;
  logic pipe_en;
  assign pipe_en       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // Input coordinates widened to the rotation datapath.
  logic signed [ROT_W-1:0] vx, vy, vz;
  assign vx = {{(ROT_W-COORD_W){s_axis_tdata[COORD_W-1]}},   s_axis_tdata[COORD_W-1:0]};
  assign vy = {{(ROT_W-COORD_W){s_axis_tdata[2*COORD_W-1]}},
               s_axis_tdata[2*COORD_W-1:COORD_W]};
  assign vz = {{(ROT_W-COORD_W){s_axis_tdata[3*COORD_W-1]}},
               s_axis_tdata[3*COORD_W-1:2*COORD_W]};

  // Rotation about X, then Y, then Z.
  logic                        rx_v, ry_v, rz_v;
  logic signed [ROT_OUT_W-1:0] rx_c, rx_s, ry_c, ry_s, rz_c, rz_s;
  logic signed [ROT_W-1:0]     rx_p, ry_p, rz_p;

  // y1 = c, z1 = s, x passes.
  vrp_rotate u_rot_x (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(s_axis_tvalid),
    .a_i(vy), .b_i(vz), .p_i(vx), .cos_i(cos_x_q), .sin_i(sin_x_q),
    .valid_o(rx_v), .c_o(rx_c), .s_o(rx_s), .p_o(rx_p)
  );

  // z2 = c, x2 = s, y1 passes.
  vrp_rotate u_rot_y (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(rx_v),
    .a_i(rx_s[ROT_W-1:0]), .b_i(rx_p), .p_i(rx_c[ROT_W-1:0]),
    .cos_i(cos_y_q), .sin_i(sin_y_q),
    .valid_o(ry_v), .c_o(ry_c), .s_o(ry_s), .p_o(ry_p)
  );

  // x3 = c, y3 = s, z2 passes.
  vrp_rotate u_rot_z (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(ry_v),
    .a_i(ry_s[ROT_W-1:0]), .b_i(ry_p), .p_i(ry_c[ROT_W-1:0]),
    .cos_i(cos_z_q), .sin_i(sin_z_q),
    .valid_o(rz_v), .c_o(rz_c), .s_o(rz_s), .p_o(rz_p)
  );

  // Depth, magnitudes, scaling and divider load.
  div_ctl_t  div_ctl    [DIV_STAGES+1];
  div_lane_t div_lane_x [DIV_STAGES+1];
  div_lane_t div_lane_y [DIV_STAGES+1];

  vrp_prep u_prep (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(rz_v),
    .x3_i(rz_c), .y3_i(rz_s), .z2_i(rz_p), .cam_dist_i(cam_dist_q),
    .ctl_o(div_ctl[0]), .lane_x_o(div_lane_x[0]), .lane_y_o(div_lane_y[0])
  );

  // Divider stages, two quotient bits each.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vrp_divstep u_divstep (
      .clk_i, .rst_ni, .en_i(pipe_en),
      .ctl_i(div_ctl[g]), .lane_x_i(div_lane_x[g]), .lane_y_i(div_lane_y[g]),
      .ctl_o(div_ctl[g+1]), .lane_x_o(div_lane_x[g+1]), .lane_y_o(div_lane_y[g+1])
    );
  end

  // Apply the sign and clamp to the screen range.
  function automatic logic [SCR_W-1:0] lane_result(div_lane_t l);
    logic [SCR_W-1:0] r;
    if (l.sat) begin
      r = l.neg ? SCR_MIN : SCR_MAX;
    end else if (l.neg) begin
      r = (l.quo > QUO_W'(SCR_MIN)) ? SCR_MIN : SCR_W'(-l.quo);
    end else begin
      r = (l.quo > QUO_W'(SCR_MAX)) ? SCR_MAX : SCR_W'(l.quo);
    end
    return r;
  endfunction

  div_ctl_t         last_ctl;
  logic [SCR_W-1:0] scr_x_d, scr_y_d, scr_x_q, scr_y_q;
  logic             inv_q;

  assign last_ctl = div_ctl[DIV_STAGES];
  assign scr_x_d  = last_ctl.invalid ? '0 : lane_result(div_lane_x[DIV_STAGES]);
  assign scr_y_d  = last_ctl.invalid ? '0 : lane_result(div_lane_y[DIV_STAGES]);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      scr_x_q <= scr_x_d;
      scr_y_q <= scr_y_d;
      inv_q   <= last_ctl.invalid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {scr_y_q, scr_x_q};
  assign m_axis_tuser  = inv_q;

  logic [5:0] stage_valid;
  assign stage_valid = {rx_v, ry_v, rz_v, div_ctl[0].valid,
                        div_ctl[DIV_STAGES].valid, out_valid_q};

`ifndef ASSERT_OFF
  // A held pipeline neither drops nor creates words in the rotation stages, at the divider's ends or at the output.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(stage_valid))
    else $error("pipeline valid bits changed during a stall");

  // An empty output register never blocks the input side.
  a_accept_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready with empty output stage");

  // A vertex at or behind the camera plane reports zero offsets.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("invalid depth with nonzero screen offsets");
`endif

endmodule

[bench/vertex_rotate_project_check.sv]
module vertex_rotate_project_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Vertex channel into the block.
  input  logic                           vtx_valid_i,
  input  logic                           vtx_ready_i,
  // vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  logic [47:0]                    vtx_data_i,
  // Screen channel out of the block.
  input  logic                           scr_valid_i,
  input  logic                           scr_ready_i,
  // screen_x [11:0], screen_y [23:12]
  input  logic [23:0]                    scr_data_i,
  // depth_invalid [0]
  input  logic                           scr_user_i,
  // Register port.
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [vrp_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [vrp_pkg::APB_DATA_W-1:0] pwdata_i,
  input  logic [vrp_pkg::APB_DATA_W-1:0] prdata_i,
  input  logic                           pready_i,
  output int                             error_count_o,
  output int                             pending_o
);
  import vrp_pkg::*;

  localparam int NUM_REGS = int'(REG_CAM_DIST) + 1;
  localparam longint SCR_HI = 2047;
  localparam longint SCR_LO = -2048;

  typedef struct packed {
    logic [SCR_W-1:0] screen_x;
    logic [SCR_W-1:0] screen_y;
    logic             depth_invalid;
  } screen_word_t;

  // Shadow copy of the angle and camera registers.
  logic signed [TRIG_W-1:0] rot_regs [NUM_REGS];
  screen_word_t             expected_screen_q [$];
  int                       mismatch_total;

  function automatic longint clamp_screen(input longint v);
    if (v > SCR_HI) return SCR_HI;
    if (v < SCR_LO) return SCR_LO;
    return v;
  endfunction

  // Rotate about X, then Y, then Z, flooring each stage back to Q.8, then
  // project onto the screen with a truncating divide by the shifted depth.
  function automatic screen_word_t project_vertex(input logic [47:0] word);
    longint x, y, z, cx, sx, cy, sy, cz, sz;
    longint y1, z1, x2, z2, x3, y3, depth;
    screen_word_t res;
    x  = longint'($signed(word[15:0]));
    y  = longint'($signed(word[31:16]));
    z  = longint'($signed(word[47:32]));
    cx = longint'(rot_regs[REG_COS_X]);
    sx = longint'(rot_regs[REG_SIN_X]);
    cy = longint'(rot_regs[REG_COS_Y]);
    sy = longint'(rot_regs[REG_SIN_Y]);
    cz = longint'(rot_regs[REG_COS_Z]);
    sz = longint'(rot_regs[REG_SIN_Z]);
    y1 = (y * cx - z * sx) >>> FRAC_SHIFT;
    z1 = (y * sx + z * cx) >>> FRAC_SHIFT;
    x2 = (x * cy + z1 * sy) >>> FRAC_SHIFT;
    z2 = (z1 * cy - x * sy) >>> FRAC_SHIFT;
    x3 = (x2 * cz - y1 * sz) >>> FRAC_SHIFT;
    y3 = (x2 * sz + y1 * cz) >>> FRAC_SHIFT;
    depth = z2 + longint'(rot_regs[REG_CAM_DIST]);
    res = '0;
    if (depth <= 0) begin
      // A point at or behind the camera plane gives no screen position.
      res.depth_invalid = 1'b1;
    end else begin
      res.screen_x = SCR_W'(clamp_screen((x3 * PROJ_SCALE) / depth));
      res.screen_y = SCR_W'(clamp_screen((y3 * PROJ_SCALE) / depth));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    screen_word_t want, got;
    logic [REG_IDX_W-1:0] idx;
    if (!rst_ni) begin
      rot_regs[REG_COS_X]    = TRIG_ONE;
      rot_regs[REG_SIN_X]    = TRIG_ZERO;
      rot_regs[REG_COS_Y]    = TRIG_ONE;
      rot_regs[REG_SIN_Y]    = TRIG_ZERO;
      rot_regs[REG_COS_Z]    = TRIG_ONE;
      rot_regs[REG_SIN_Z]    = TRIG_ZERO;
      rot_regs[REG_CAM_DIST] = CAM_DIST_RST;
      expected_screen_q.delete();
      mismatch_total = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      // Compare each screen word with the oldest prediction.
      if (scr_valid_i && scr_ready_i) begin
        got = '{screen_x: scr_data_i[11:0], screen_y: scr_data_i[23:12],
                depth_invalid: scr_user_i};
        if (expected_screen_q.size() == 0) begin
          $error("unexpected screen word: screen_x %0d, screen_y %0d, depth_invalid %0d",
                 $signed(got.screen_x), $signed(got.screen_y), got.depth_invalid);
          mismatch_total++;
        end else begin
          want = expected_screen_q.pop_front();
          if (got.screen_x !== want.screen_x) begin
            $error("screen_x: expected %0d, got %0d",
                   $signed(want.screen_x), $signed(got.screen_x));
            mismatch_total++;
          end
          if (got.screen_y !== want.screen_y) begin
            $error("screen_y: expected %0d, got %0d",
                   $signed(want.screen_y), $signed(got.screen_y));
            mismatch_total++;
          end
          if (got.depth_invalid !== want.depth_invalid) begin
            $error("depth_invalid: expected %0d, got %0d",
                   want.depth_invalid, got.depth_invalid);
            mismatch_total++;
          end
        end
      end

      // Every accepted vertex gives exactly one screen word.
      if (vtx_valid_i && vtx_ready_i) begin
        expected_screen_q.push_back(project_vertex(vtx_data_i));
      end

      // Register writes update the shadow copy; reads are checked against it.
      if (psel_i && penable_i && pready_i) begin
        idx = paddr_i[APB_ADDR_W-1:2];
        if (idx <= REG_CAM_DIST) begin
          if (pwrite_i) begin
            rot_regs[idx] = pwdata_i[TRIG_W-1:0];
          end else if (prdata_i[TRIG_W-1:0] !== rot_regs[idx]) begin
            $error("prdata: expected %0d, got %0d",
                   rot_regs[idx], $signed(prdata_i[TRIG_W-1:0]));
            mismatch_total++;
          end
        end
      end

      error_count_o <= mismatch_total;
      pending_o     <= expected_screen_q.size();
    end
  end

endmodule

[bench/vertex_rotate_project_tb.sv]
module vertex_rotate_project_tb;
  import vrp_pkg::*;

  localparam int PIPE_LATENCY = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 250;

  // Address past the last register; writes there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_request  = 1'b0;
  bit hold_taken    = 1'b0;
  int quiet_cycles  = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  vertex_rotate_project dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  vertex_rotate_project_check u_projection_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vtx_valid_i   (s_axis_tvalid),
    .vtx_ready_i   (s_axis_tready),
    .vtx_data_i    (s_axis_tdata),
    .scr_valid_i   (m_axis_tvalid),
    .scr_ready_i   (m_axis_tready),
    .scr_data_i    (m_axis_tdata),
    .scr_user_i    (m_axis_tuser),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .error_count_o (mismatches),
    .pending_o     (pending)
  );

  function automatic logic [47:0] pack_vertex(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // Coordinate spread: mostly near the origin so projections land on screen,
  // some medium, some corner values and some over the full range.
  function automatic int random_coord(input int spread);
    unique case (spread)
      0: return int'($urandom_range(4096)) - 2048;
      1: return int'($urandom_range(16384)) - 8192;
      2: begin
        unique case ($urandom_range(4))
          0:       return -32768;
          1:       return -1;
          2:       return 0;
          3:       return 1;
          default: return 32767;
        endcase
      end
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic logic [47:0] random_vertex();
    int pick;
    int spread;
    pick = $urandom_range(9);
    if (pick <= 4) spread = 0;
    else if (pick == 5) spread = 1;
    else if (pick == 6) spread = 2;
    else spread = 3;
    return pack_vertex(random_coord(spread), random_coord(spread), random_coord(spread));
  endfunction

  // Offer one vertex word, idling first at the current rate. The valid stays
  // high afterwards so back-to-back words need no toggle.
  task automatic send_vertex(input logic [47:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {16'($urandom), 16'($urandom), 16'($urandom)};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted screen word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // One register transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic is_write,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // Load all registers (with junk in the unused upper bits), poke the address
  // past the end, then read everything back.
  task automatic set_rotation(input int cx, input int sx, input int cy, input int sy,
                              input int cz, input int sz, input int cam);
    apb_access(REG_COS_X,    1'b1, {16'($urandom), 16'(cx)});
    apb_access(REG_SIN_X,    1'b1, {16'($urandom), 16'(sx)});
    apb_access(REG_COS_Y,    1'b1, {16'($urandom), 16'(cy)});
    apb_access(REG_SIN_Y,    1'b1, {16'($urandom), 16'(sy)});
    apb_access(REG_COS_Z,    1'b1, {16'($urandom), 16'(cz)});
    apb_access(REG_SIN_Z,    1'b1, {16'($urandom), 16'(sz)});
    apb_access(REG_CAM_DIST, 1'b1, {16'($urandom), 16'(cam)});
    apb_access(REG_UNUSED,   1'b1, $urandom);
    for (int i = 0; i <= int'(REG_CAM_DIST); i++) begin
      apb_access(REG_IDX_W'(i), 1'b0, '0);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int trig_corner();
    return (int'($urandom_range(2)) - 1) * 16384;
  endfunction

  // Pick a new rotation: real angles most of the time, otherwise arbitrary
  // in-range sine and cosine pairs or their extreme values.
  task automatic random_rotation(input bit corners);
    int  trig [6];
    int  cam;
    real ang;
    for (int i = 0; i < 6; i += 2) begin
      if (corners) begin
        trig[i]   = trig_corner();
        trig[i+1] = trig_corner();
      end else if ($urandom_range(3) == 0) begin
        trig[i]   = int'($urandom_range(32768)) - 16384;
        trig[i+1] = int'($urandom_range(32768)) - 16384;
      end else begin
        ang       = real'($urandom_range(359)) * 3.14159265358979 / 180.0;
        trig[i]   = $rtoi(16384.0 * $cos(ang));
        trig[i+1] = $rtoi(16384.0 * $sin(ang));
      end
    end
    if (corners) begin
      unique case ($urandom_range(3))
        0:       cam = -32768;
        1:       cam = 0;
        2:       cam = 1;
        default: cam = 32767;
      endcase
    end else if ($urandom_range(4) == 0) begin
      cam = int'($urandom_range(65535)) - 32768;
    end else begin
      cam = $urandom_range(8192, 256);
    end
    set_rotation(trig[0], trig[1], trig[2], trig[3], trig[4], trig[5], cam);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity rotation straight out of reset, camera at 10.0.
    send_vertex(pack_vertex(0, 0, 0));
    send_vertex(pack_vertex(32767, 32767, 32767));
    send_vertex(pack_vertex(-32768, -32768, -32768));
    send_vertex(pack_vertex(32767, -32768, 0));
    send_vertex(pack_vertex(256, 256, 0));
    send_vertex(pack_vertex(100, -100, 0));
    send_vertex(pack_vertex(-1, -1, 0));
    // Depth exactly zero, then negative.
    send_vertex(pack_vertex(512, 512, -2560));
    send_vertex(pack_vertex(512, 512, -2561));
    // Depth of one: offsets far off screen saturate both ways.
    send_vertex(pack_vertex(256, -256, -2559));
    drain();

    // Extreme register values, far camera.
    set_rotation(-16384, 16384, -16384, 16384, -16384, 16384, 32767);
    send_vertex(pack_vertex(32767, -32768, 32767));
    send_vertex(pack_vertex(-32768, 32767, -32768));
    send_vertex(pack_vertex(256, 512, 768));
    drain();

    // Opposite extremes with the camera distance at its most negative value.
    set_rotation(16384, -16384, 16384, -16384, 16384, -16384, -32768);
    send_vertex(pack_vertex(0, 0, 0));
    send_vertex(pack_vertex(32767, 32767, 32767));
    drain();

    // Quarter turns on every axis.
    set_rotation(0, 16384, 0, 16384, 0, 16384, 2560);
    send_vertex(pack_vertex(256, 512, 768));
    send_vertex(pack_vertex(-32768, 0, 32767));
    drain();

    // Random phases, each with its own rotation and one of four idling patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      random_rotation(p == NUM_PHASES - 1);
      unique case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      // Let the pipeline fill up against a stalled output.
      if (p == 4) hold_request = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_vertex(random_vertex());
        if (p == 6 && n == PHASE_WORDS / 2) drain();
      end
      drain();
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
